FILE: hw/rtl/wsfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Shared types and constants of the frame receiver.
// ----------------------------------------------------------------------------
package wsfr_pkg;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4087;
    localparam logic [15:0] MAX_PING_RESET    = 16'd500;
    localparam logic [6:0]  LEN7_EXT16        = 7'd126;
    localparam logic [6:0]  LEN7_EXT64        = 7'd127;
    localparam logic [15:0] MIN_EXT_LEN       = 16'd126;

    localparam logic [0:0]  REG_MAX_PAYLOAD   = 1'b0;
    localparam logic [0:0]  REG_MAX_PING      = 1'b1;

    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_EXT_HI = 3'd2,
        PH_EXT_LO = 3'd3,
        PH_MASK   = 3'd4,
        PH_DATA   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        KIND_CONT   = 3'd0,
        KIND_TEXT   = 3'd1,
        KIND_BINARY = 3'd2,
        KIND_PING   = 3'd3,
        KIND_PONG   = 3'd4,
        KIND_CLOSE  = 3'd5,
        KIND_BAD    = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNMASKED  = 3'd1,
        ST_LEN64     = 3'd2,
        ST_SHORT_EXT = 3'd3,
        ST_BIG_PING  = 3'd4,
        ST_CLOSE     = 3'd5,
        ST_BAD_OP    = 3'd6,
        ST_TOO_LONG  = 3'd7
    } t_status;

    localparam logic [6:0] OP_CONT   = 7'd0;
    localparam logic [6:0] OP_TEXT   = 7'd1;
    localparam logic [6:0] OP_BINARY = 7'd2;
    localparam logic [6:0] OP_CLOSE  = 7'd8;
    localparam logic [6:0] OP_PING   = 7'd9;
    localparam logic [6:0] OP_PONG   = 7'd10;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       has_byte;
        logic [2:0] kind;
        logic       last;
        t_status    status;
    } t_op;

endpackage
`default_nettype wire

FILE: hw/rtl/wsfr_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame receiver channels
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface wsfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [2:0] frame_kind;
    logic       last;
    logic [2:0] status;

    modport source (output valid, output payload_byte, output has_byte,
                    output frame_kind, output last, output status, input ready);
    modport sink   (input valid, input payload_byte, input has_byte,
                    input frame_kind, input last, input status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/wsfr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame receiver front end
// Parses the frame header, holds the mask key and queues one op per result.
// ----------------------------------------------------------------------------
module wsfr_front
    import wsfr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wsfr_rx_if.sink     i_rx,
    input  wire logic [15:0] i_max_payload,
    input  wire logic [15:0] i_max_ping,
    input  wire logic   i_q_full,
    output logic        o_push,
    output t_op         o_op
);

    t_phase      r_phase, n_phase;
    t_kind       r_kind, n_kind;
    logic [15:0] r_len, n_len;
    logic [31:0] r_key, n_key;
    logic [15:0] r_idx, n_idx;
    logic        r_dead;

    logic        acc;
    logic [7:0]  b;
    logic [6:0]  len7;
    logic [15:0] len_now;
    t_status     len_err;
    logic        is_last;
    logic        mask_done;
    logic [2:0]  out_kind;
    logic [7:0]  key_byte;

    assign i_rx.ready = !i_q_full;
    assign acc        = i_rx.valid && !i_q_full && !r_dead;
    assign b          = i_rx.rx_byte;
    assign len7       = b[6:0];
    assign len_now    = (r_phase == PH_HDR1) ? {9'd0, len7} : {r_len[15:8], b};
    assign is_last    = (({1'b0, r_idx} + 17'd1) >= {1'b0, r_len});
    assign mask_done  = (r_idx[1:0] == 2'd3);
    assign out_kind   = (r_kind > KIND_PONG) ? KIND_CONT : r_kind;

    always_comb begin
        priority if (r_kind == KIND_CLOSE) begin
            len_err = ST_CLOSE;
        end else if (r_kind == KIND_BAD) begin
            len_err = ST_BAD_OP;
        end else if (r_kind == KIND_PING && len_now > i_max_ping) begin
            len_err = ST_BIG_PING;
        end else if (len_now > i_max_payload) begin
            len_err = ST_TOO_LONG;
        end else begin
            len_err = ST_OK;
        end
    end

    always_comb begin
        unique case (r_idx[1:0])
            2'd0: key_byte = r_key[31:24];
            2'd1: key_byte = r_key[23:16];
            2'd2: key_byte = r_key[15:8];
            2'd3: key_byte = r_key[7:0];
            default: key_byte = r_key[7:0];
        endcase
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (acc) begin
            unique case (r_phase)
                PH_HDR0: n_phase = PH_HDR1;
                PH_HDR1: begin
                    priority if (!b[7] || len7 == LEN7_EXT64) begin
                        n_phase = PH_HDR0;
                    end else if (len7 == LEN7_EXT16) begin
                        n_phase = PH_EXT_HI;
                    end else if (len_err != ST_OK) begin
                        n_phase = PH_HDR0;
                    end else begin
                        n_phase = PH_MASK;
                    end
                end
                PH_EXT_HI: n_phase = PH_EXT_LO;
                PH_EXT_LO: begin
                    if (len_now < MIN_EXT_LEN || len_err != ST_OK) begin
                        n_phase = PH_HDR0;
                    end else begin
                        n_phase = PH_MASK;
                    end
                end
                PH_MASK: begin
                    if (mask_done) begin
                        n_phase = (r_len == 16'd0) ? PH_HDR0 : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (is_last) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: n_phase = PH_HDR0;
            endcase
        end
    end

    // queued ops
    always_comb begin
        o_push          = 1'b0;
        o_op.data       = 8'd0;
        o_op.key        = 8'd0;
        o_op.has_byte   = 1'b0;
        o_op.kind       = out_kind;
        o_op.last       = 1'b1;
        o_op.status     = ST_OK;
        if (acc) begin
            unique case (r_phase)
                PH_HDR1: begin
                    priority if (!b[7]) begin
                        o_push      = 1'b1;
                        o_op.status = ST_UNMASKED;
                    end else if (len7 == LEN7_EXT64) begin
                        o_push      = 1'b1;
                        o_op.status = ST_LEN64;
                    end else if (len7 != LEN7_EXT16 && len_err != ST_OK) begin
                        o_push      = 1'b1;
                        o_op.status = len_err;
                    end else begin
                        o_push      = 1'b0;
                    end
                end
                PH_EXT_LO: begin
                    priority if (len_now < MIN_EXT_LEN) begin
                        o_push      = 1'b1;
                        o_op.status = ST_SHORT_EXT;
                    end else if (len_err != ST_OK) begin
                        o_push      = 1'b1;
                        o_op.status = len_err;
                    end else begin
                        o_push      = 1'b0;
                    end
                end
                PH_MASK: begin
                    o_push = mask_done && r_len == 16'd0 &&
                             (r_kind == KIND_PING || r_kind == KIND_PONG);
                end
                PH_DATA: begin
                    o_push        = 1'b1;
                    o_op.data     = b;
                    o_op.key      = key_byte;
                    o_op.has_byte = 1'b1;
                    o_op.last     = is_last;
                end
                default: o_push = 1'b0;
            endcase
        end
    end

    // datapath next values
    always_comb begin
        n_kind = r_kind;
        n_len  = r_len;
        n_key  = r_key;
        n_idx  = 16'd0;
        unique case (r_phase)
            PH_HDR0: begin
                priority if (len7 == OP_CONT) begin
                    n_kind = KIND_CONT;
                end else if (len7 == OP_TEXT) begin
                    n_kind = KIND_TEXT;
                end else if (len7 == OP_BINARY) begin
                    n_kind = KIND_BINARY;
                end else if (len7 == OP_PING) begin
                    n_kind = KIND_PING;
                end else if (len7 == OP_PONG) begin
                    n_kind = KIND_PONG;
                end else if (len7 == OP_CLOSE) begin
                    n_kind = KIND_CLOSE;
                end else begin
                    n_kind = KIND_BAD;
                end
                n_len = 16'd0;
                n_key = 32'd0;
            end
            PH_HDR1:   n_len = len_now;
            PH_EXT_HI: n_len = {b, 8'd0};
            PH_EXT_LO: n_len = len_now;
            PH_MASK: begin
                n_key = {r_key[23:0], b};
                n_idx = mask_done ? 16'd0 : r_idx + 16'd1;
            end
            PH_DATA: n_idx = is_last ? 16'd0 : r_idx + 16'd1;
            default: n_idx = 16'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_kind  <= KIND_CONT;
            r_len   <= 16'd0;
            r_key   <= 32'd0;
            r_idx   <= 16'd0;
            r_dead  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (acc) begin
                r_kind <= n_kind;
                r_len  <= n_len;
                r_key  <= n_key;
                r_idx  <= n_idx;
                if (o_push && o_op.status != ST_OK) begin
                    r_dead <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/wsfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame receiver op queue
// Short FIFO between the header parser and the output stage.
// ----------------------------------------------------------------------------
module wsfr_queue
    import wsfr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_op       o_op
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/wsfr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame receiver back end
// Unmasks queued bytes and holds the result in the output register.
// ----------------------------------------------------------------------------
module wsfr_back
    import wsfr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_op  i_op,
    output logic      o_pop,
    wsfr_res_if.source o_frm
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_has;
    logic [2:0] r_kind;
    logic       r_last;
    logic [2:0] r_status;

    assign o_pop = !i_empty && (!r_valid || o_frm.ready);

    assign o_frm.valid        = r_valid;
    assign o_frm.payload_byte = r_byte;
    assign o_frm.has_byte     = r_has;
    assign o_frm.frame_kind   = r_kind;
    assign o_frm.last         = r_last;
    assign o_frm.status       = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_frm.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte   <= i_op.data ^ i_op.key;
            r_has    <= i_op.has_byte;
            r_kind   <= i_op.kind;
            r_last   <= i_op.last;
            r_status <= i_op.status;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/websocket_frame_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// Server-side frame deframer with APB limit registers.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while the op queue has room and gives at
// most one result per byte. A result passes through the op queue and then
// the output register. The header parser handles every byte combinationally,
// so the sustained rate is one byte per clock while the result side keeps
// up. Errors stop the stream until reset. Registers: 0x0 largest payload
// length, 0x4 largest ping length.
module websocket_frame_receiver_top
    import wsfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    wsfr_rx_if.sink          i_rx,
    wsfr_res_if.source       o_frm,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] r_max_payload;
    logic [15:0] r_max_ping;
    logic        cfg_wr;
    logic        push, pop, q_full, q_empty;
    t_op         push_op, pop_op;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MAX_PING) ? {16'd0, r_max_ping}
                                               : {16'd0, r_max_payload};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
            r_max_ping    <= MAX_PING_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MAX_PAYLOAD: r_max_payload <= pwdata[15:0];
                REG_MAX_PING:    r_max_ping    <= pwdata[15:0];
                default:         r_max_ping    <= r_max_ping;
            endcase
        end
    end

    wsfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx          (i_rx),
        .i_max_payload (r_max_payload),
        .i_max_ping    (r_max_ping),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_op          (push_op)
    );

    wsfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_op    (pop_op)
    );

    wsfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_op    (pop_op),
        .o_pop   (pop),
        .o_frm   (o_frm)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("op queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("op queue read while empty");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frm.valid && o_frm.status != ST_OK) |->
            (o_frm.last && !o_frm.has_byte && o_frm.payload_byte == 8'd0))
        else $error("error result with payload or without last");

    a_push_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop) |=> o_frm.valid)
        else $error("popped op did not reach the output register");

endmodule
`default_nettype wire
